/* rtl/relative_path_normalizer_assert.svh */
// Assertion macros for the relative path normalizer.
// Included by the top level; no dependencies.
`ifndef RELATIVE_PATH_NORMALIZER_ASSERT_SVH
`define RELATIVE_PATH_NORMALIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define RPN_ASSERT(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("rpn assertion failed");
`define RPN_NEVER(label, clock, reset, cond) \
  label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
    else $error("rpn forbidden condition seen");
`else
`define RPN_ASSERT(label, clock, reset, prop)
`define RPN_NEVER(label, clock, reset, cond)
`endif

`endif

/* rtl/rpn_pkg.sv */
// Shared types, character constants and helpers for the path normalizer.
// No dependencies.
package rpn_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;  // queue pointer width
  localparam int QCW    = 3;  // queue count width (holds QDEPTH)

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_ABSOLUTE = 3'd2,
    ST_DRIVE    = 3'd3,
    ST_PARENT   = 3'd4,
    ST_CONTROL  = 3'd5
  } status_t;

  // segment state: nothing, "." held, ".." held, segment being emitted
  typedef enum logic [3:0] {
    HELD_NONE   = 4'b0001,
    HELD_DOT    = 4'b0010,
    HELD_DOTDOT = 4'b0100,
    HELD_LIVE   = 4'b1000
  } held_t;

  // one input transaction's worth of results, expanded by the back end
  typedef struct packed {
    logic       slash;
    logic [1:0] ndots;
    logic       byte_en;
    logic [7:0] data;
    logic       done;
    status_t    status;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    is_sep = (c == CH_SLASH) || (c == CH_BSLASH);
  endfunction

endpackage

/* rtl/relative_path_normalizer.sv */
// Relative path normalizer: byte stream in, normalized path bytes and status out.
// Path: transaction -> queue -> back end command register -> registered m_* output.
// Throughput: one input transaction per cycle while each yields one result and m_tready is
// high; one yielding k results holds the back end for all k; the 4-deep queue absorbs it.
// Reset: rst synchronous, active high; clears path state, queue and output valid.
`include "relative_path_normalizer_assert.svh"

module relative_path_normalizer (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] has_char
  input  logic        s_tlast,   // path_end
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic [1:0]  m_tuser,   // [0] byte_valid, [1] done_res
  output logic        m_tlast    // run_end
);

  // Front end classifies each byte and turns the transaction into a compact
  // command: optional '/', up to two released dots, the byte itself, and
  // the final status when the path ends. Transactions with nothing to say
  // are dropped there.
  rpn_pkg::cmd_slot_t push;
  rpn_pkg::cmd_slot_t head;
  logic               q_full;
  logic               pop;

  rpn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push)
  );

  // Decouples the two halves so output stalls do not stop byte intake
  // until the queue fills.
  rpn_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  // Back end walks each command piece by piece, one result per cycle while
  // m_tready allows, marking the last piece of the transaction with tlast.
  rpn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // every result is exactly one of byte or status
  `RPN_ASSERT(a_kind_exclusive, clk, rst, m_tvalid |-> (m_tuser[0] ^ m_tuser[1]))
  // a status result always closes its transaction's run
  `RPN_ASSERT(a_status_is_last, clk, rst, (m_tvalid && m_tuser[1]) |-> m_tlast)
  // byte results carry an ok status field
  `RPN_NEVER(a_byte_status_zero, clk, rst, m_tvalid && m_tuser[0] && (m_tdata[10:8] != 3'd0))
  // a queue pop only happens when there is something queued
  `RPN_NEVER(a_pop_nonempty, clk, rst, pop && !head.valid)

endmodule

/* rtl/rpn_front.sv */
// Front end: accepts path bytes, tracks segment and error state,
// and queues at most one result command per transaction. Uses rpn_pkg.
module rpn_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] ch
  input  logic              s_tuser,   // [0] has_char
  input  logic              s_tlast,   // path_end
  input  logic              q_full,
  output rpn_pkg::cmd_slot_t push
);

  logic [1:0]       char_position, char_position_next;
  logic             first_is_letter, first_is_letter_next;
  rpn_pkg::held_t   held, held_next;
  logic             any_kept, any_kept_next;
  rpn_pkg::status_t err, err_next;
  rpn_pkg::cmd_t    cmd;
  logic             accept;
  logic [7:0]       c;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;
  assign c        = s_tdata;

  always_comb begin
    char_position_next   = char_position;
    first_is_letter_next = first_is_letter;
    held_next            = held;
    any_kept_next        = any_kept;
    err_next             = err;
    cmd                  = '0;
    cmd.status           = rpn_pkg::ST_OK;

    if (s_tuser) begin
      if (char_position != 2'd2) begin
        char_position_next = char_position + 2'd1;
      end
      if (char_position == 2'd0) begin
        first_is_letter_next = rpn_pkg::is_letter(c);
      end
      if (err == rpn_pkg::ST_OK) begin
        if (char_position == 2'd0 && rpn_pkg::is_sep(c)) begin
          err_next = rpn_pkg::ST_ABSOLUTE;
        end else if (char_position == 2'd1 && first_is_letter && c == rpn_pkg::CH_COLON) begin
          err_next = rpn_pkg::ST_DRIVE;
        end else if (rpn_pkg::is_sep(c)) begin
          if (held == rpn_pkg::HELD_DOTDOT) begin
            err_next = rpn_pkg::ST_PARENT;
          end
          held_next = rpn_pkg::HELD_NONE;
        end else if (c < rpn_pkg::CH_SPACE || c == rpn_pkg::CH_DEL) begin
          err_next = rpn_pkg::ST_CONTROL;
        end else if (c == rpn_pkg::CH_DOT && held == rpn_pkg::HELD_NONE) begin
          held_next = rpn_pkg::HELD_DOT;
        end else if (c == rpn_pkg::CH_DOT && held == rpn_pkg::HELD_DOT) begin
          held_next = rpn_pkg::HELD_DOTDOT;
        end else begin
          if (held != rpn_pkg::HELD_LIVE) begin
            // open a kept segment, releasing any held dots
            cmd.slash = any_kept;
            case (held)
              rpn_pkg::HELD_DOT:    cmd.ndots = 2'd1;
              rpn_pkg::HELD_DOTDOT: cmd.ndots = 2'd2;
              default:              cmd.ndots = 2'd0;
            endcase
            any_kept_next = 1'b1;
            held_next     = rpn_pkg::HELD_LIVE;
          end
          cmd.byte_en = 1'b1;
          cmd.data    = c;
        end
      end
    end

    if (s_tlast) begin
      cmd.done = 1'b1;
      if (err_next == rpn_pkg::ST_OK && held_next == rpn_pkg::HELD_DOTDOT) begin
        cmd.status = rpn_pkg::ST_PARENT;
      end else if (err_next == rpn_pkg::ST_OK && !any_kept_next) begin
        cmd.status = rpn_pkg::ST_EMPTY;
      end else begin
        cmd.status = err_next;
      end
      char_position_next   = 2'd0;
      first_is_letter_next = 1'b0;
      held_next            = rpn_pkg::HELD_NONE;
      any_kept_next        = 1'b0;
      err_next             = rpn_pkg::ST_OK;
    end
  end

  assign push.valid = accept && (cmd.byte_en || cmd.done);
  assign push.cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position   <= 2'd0;
      first_is_letter <= 1'b0;
      held            <= rpn_pkg::HELD_NONE;
      any_kept        <= 1'b0;
      err             <= rpn_pkg::ST_OK;
    end else if (accept) begin
      char_position   <= char_position_next;
      first_is_letter <= first_is_letter_next;
      held            <= held_next;
      any_kept        <= any_kept_next;
      err             <= err_next;
    end
  end

endmodule

/* rtl/rpn_queue.sv */
// Short command queue between front and back ends.
// Uses rpn_pkg for depth and command type.
module rpn_queue (
  input  logic               clk,
  input  logic               rst,
  input  rpn_pkg::cmd_slot_t push,
  output logic               full,
  input  logic               pop,
  output rpn_pkg::cmd_slot_t head
);

  rpn_pkg::cmd_t           mem [rpn_pkg::QDEPTH];
  logic [rpn_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [rpn_pkg::QCW-1:0] count;
  logic                    do_pop;

  assign full       = (count == rpn_pkg::QCW'(rpn_pkg::QDEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + rpn_pkg::QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + rpn_pkg::QAW'(1);
      end
      if (push.valid && !do_pop) begin
        count <= count + rpn_pkg::QCW'(1);
      end else if (!push.valid && do_pop) begin
        count <= count - rpn_pkg::QCW'(1);
      end
    end
  end

endmodule

/* rtl/rpn_back.sv */
// Back end: expands queued commands into one result per cycle while
// m_tready allows, behind a registered output stage. Uses rpn_pkg.
module rpn_back (
  input  logic               clk,
  input  logic               rst,
  input  rpn_pkg::cmd_slot_t head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,  // [7:0] out_byte, [10:8] status, rest zero
  output logic [1:0]         m_tuser,  // [0] byte_valid, [1] done_res
  output logic               m_tlast   // run_end
);

  rpn_pkg::cmd_t    cur, rest;
  logic             cur_valid;
  logic             advance, last;
  logic [7:0]       p_byte;
  logic             p_valid, p_done;
  rpn_pkg::status_t p_status;

  always_comb begin
    rest     = cur;
    p_byte   = 8'h00;
    p_valid  = 1'b0;
    p_done   = 1'b0;
    p_status = rpn_pkg::ST_OK;
    if (cur.slash) begin
      rest.slash = 1'b0;
      p_byte     = rpn_pkg::CH_SLASH;
      p_valid    = 1'b1;
    end else if (cur.ndots != 2'd0) begin
      rest.ndots = cur.ndots - 2'd1;
      p_byte     = rpn_pkg::CH_DOT;
      p_valid    = 1'b1;
    end else if (cur.byte_en) begin
      rest.byte_en = 1'b0;
      p_byte       = cur.data;
      p_valid      = 1'b1;
    end else begin
      rest.done = 1'b0;
      p_done    = 1'b1;
      p_status  = cur.status;
    end
  end

  assign last    = !(rest.slash || rest.ndots != 2'd0 || rest.byte_en || rest.done);
  assign advance = cur_valid && (!m_tvalid || m_tready);
  assign pop     = head.valid && (!cur_valid || (advance && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (!cur_valid || (advance && last)) begin
      cur_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cur_valid || (advance && last)) begin
      cur <= head.cmd;
    end else if (advance) begin
      cur <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'b00000, p_status, p_byte};
      m_tuser <= {p_done, p_valid};
      m_tlast <= last;
    end
  end

endmodule
